/* rtl/prv_pkg.sv */
// Shared types and constants for the peptide ribbon vertex block.
// Used by every module under rtl; depends on nothing else.

package prv_pkg;

   localparam int COORD_W  = 24;   // Q11.12 coordinate
   localparam int DIFF_W   = 25;   // difference of two coordinates
   localparam int NORM_W   = 16;   // Q1.14 normal component
   localparam int HW_W     = 16;   // half width register
   localparam int OFF_W    = 18;   // signed offset component
   localparam int ACC_W    = 64;   // cross product accumulator
   localparam int MUL_W    = 32;   // shared multiplier operand width
   localparam int RED_W    = 30;   // reduced magnitudes stay below 2^30
   localparam int RAD_W    = 62;   // sum of three reduced squares
   localparam int ROOT_W   = 31;
   localparam int NUM_W    = 48;   // scaled dividend
   localparam int QUO_W    = 17;

   localparam logic [HW_W-1:0] UNIT_SCALE = 16'd16384;
   localparam logic [HW_W-1:0] HW_RESET   = 16'd10240;

   typedef enum logic [1:0] {
      PH_CA1,
      PH_OXY,
      PH_CA2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XMUL,
      ST_XACC,
      ST_CHECK,
      ST_REDUCE,
      ST_SQMUL,
      ST_SQACC,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DMUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0]  a;     // ca2 - ca1
      logic [2:0][DIFF_W-1:0]  b;     // o - ca1
      logic [2:0][COORD_W-1:0] mid;   // floor midpoint of the carbons
   } job_type;

   typedef struct packed {
      logic [2:0][NORM_W-1:0]  nrm;
      logic [2:0][COORD_W-1:0] edge2;
      logic [2:0][COORD_W-1:0] edge1;
      logic                    degen;
   } result_type;

endpackage

/* rtl/prv_sqrt.sv */
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on prv_pkg for widths.

module prv_sqrt
   import prv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  rad,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [RAD_W-1:0]  keep_ff, keep_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  rem_sh, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      keep_in = keep_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = rad;
         keep_in = rad;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      keep_ff <= keep_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

`ifndef NO_ASSERTIONS
   a_root_low : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, root_ff} * {1'b0, root_ff}) <= {2'b00, keep_ff})
      else $error("square root too large");
   a_root_high : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, root_ff} + 1'b1) * ({1'b0, root_ff} + 1'b1) > {2'b00, keep_ff})
      else $error("square root too small");
`endif

endmodule

/* rtl/prv_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on prv_pkg for widths; quotient must fit QUO_W bits.

module prv_div
   import prv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic              done,
   output logic [QUO_W-1:0]  quo
);

   localparam int CNT_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]  sh_ff, sh_in;
   logic [ROOT_W:0]   rd;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      rd      = {rem_ff, sh_ff[QUO_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[NUM_W-1 -: ROOT_W];
         sh_in   = num[QUO_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         if (rd >= {1'b0, den_ff}) begin
            rem_in = ROOT_W'(rd - {1'b0, den_ff});
            sh_in  = {sh_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rd[ROOT_W-1:0];
            sh_in  = {sh_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

   assign done = done_ff;
   assign quo  = sh_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");
`endif

endmodule

/* rtl/prv_core.sv */
// Sequencer around one shared multiplier, the square root and the divider.
// Depends on prv_pkg, prv_sqrt and prv_div.

module prv_core
   import prv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            job_go,
   input  job_type         job,
   input  logic [HW_W-1:0] half_width,
   output logic            idle,
   output logic            res_valid,
   input  logic            res_take,
   output result_type      res
);

   seq_state_type            state_ff, state_in;
   logic                     pass_ff, pass_in;
   logic [1:0]               k_ff, k_in;
   logic                     term_ff, term_in;
   logic                     degen_ff, degen_in;
   logic signed [DIFF_W-1:0] a_ff [3];
   logic signed [DIFF_W-1:0] a_in [3];
   logic signed [DIFF_W-1:0] b_ff [3];
   logic signed [DIFF_W-1:0] b_in [3];
   logic [COORD_W-1:0]       mid_ff [3];
   logic [COORD_W-1:0]       mid_in [3];
   logic signed [ACC_W-1:0]  vec_ff [3];
   logic signed [ACC_W-1:0]  vec_in [3];
   logic [ACC_W-1:0]         mag_ff [3];
   logic [ACC_W-1:0]         mag_in [3];
   logic                     neg_ff [3];
   logic                     neg_in [3];
   logic [NORM_W-1:0]        nrm_ff [3];
   logic [NORM_W-1:0]        nrm_in [3];
   logic signed [OFF_W-1:0]  off_ff [3];
   logic signed [OFF_W-1:0]  off_in [3];
   logic [RAD_W-1:0]         sum_ff, sum_in;
   logic [ROOT_W-1:0]        norm_ff, norm_in;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [MUL_W-1:0]  cs_val [3];
   logic signed [MUL_W-1:0]  u_val [3];
   logic signed [MUL_W-1:0]  v_val [3];
   logic [1:0]               j_idx, kk_idx;
   logic                     sq_start, sq_done;
   logic [ROOT_W-1:0]        sq_root;
   logic                     dv_start, dv_done;
   logic [QUO_W-1:0]         dv_quo;
   logic [NUM_W-1:0]         dv_num;
   logic [HW_W-1:0]          scale;
   logic signed [OFF_W-1:0]  q_signed;
   logic                     vec_zero, any_wide;

   function automatic logic [COORD_W-1:0] sat24(input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W+1:0] hi, lo;
      hi = (COORD_W+2)'(2**(COORD_W-1) - 1);
      lo = -(COORD_W+2)'(2**(COORD_W-1));
      if (v > hi) begin
         sat24 = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat24 = lo[COORD_W-1:0];
      end else begin
         sat24 = v[COORD_W-1:0];
      end
   endfunction

   prv_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sum_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   prv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (norm_ff),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   // operand selection for the shared multiplier
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cs_val[i] = neg_ff[i] ? -$signed({2'b00, mag_ff[i][RED_W-1:0]})
                               :  $signed({2'b00, mag_ff[i][RED_W-1:0]});
         u_val[i]  = pass_ff ? cs_val[i] : MUL_W'(a_ff[i]);
         v_val[i]  = pass_ff ? MUL_W'(a_ff[i]) : MUL_W'(b_ff[i]);
      end
      case (k_ff)
         2'd0: begin j_idx = 2'd1; kk_idx = 2'd2; end
         2'd1: begin j_idx = 2'd2; kk_idx = 2'd0; end
         default: begin j_idx = 2'd0; kk_idx = 2'd1; end
      endcase
      scale = pass_ff ? half_width : UNIT_SCALE;
      case (state_ff)
         ST_SQMUL: begin
            mul_a = $signed({2'b00, mag_ff[k_ff][RED_W-1:0]});
            mul_b = mul_a;
         end
         ST_DMUL: begin
            mul_a = $signed({2'b00, mag_ff[k_ff][RED_W-1:0]});
            mul_b = $signed({{(MUL_W-HW_W){1'b0}}, scale});
         end
         default: begin
            mul_a = term_ff ? u_val[kk_idx] : u_val[j_idx];
            mul_b = term_ff ? v_val[j_idx]  : v_val[kk_idx];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      k_in     = k_ff;
      term_in  = term_ff;
      degen_in = degen_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      mid_in   = mid_ff;
      vec_in   = vec_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      nrm_in   = nrm_ff;
      off_in   = off_ff;
      sum_in   = sum_ff;
      norm_in  = norm_ff;
      sq_start = 1'b0;
      dv_start = 1'b0;
      dv_num   = prod_ff[NUM_W-1:0] + {{(NUM_W-ROOT_W+1){1'b0}}, norm_ff[ROOT_W-1:1]};
      q_signed = $signed({1'b0, dv_quo});
      if (neg_ff[k_ff]) begin
         q_signed = -$signed({1'b0, dv_quo});
      end
      vec_zero = (vec_ff[0] == '0) && (vec_ff[1] == '0) && (vec_ff[2] == '0);
      any_wide = (|mag_ff[0][ACC_W-1:RED_W]) || (|mag_ff[1][ACC_W-1:RED_W]) ||
                 (|mag_ff[2][ACC_W-1:RED_W]);
      idle      = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (job_go) begin
               for (int i = 0; i < 3; i++) begin
                  a_in[i]   = $signed(job.a[i]);
                  b_in[i]   = $signed(job.b[i]);
                  mid_in[i] = job.mid[i];
               end
               pass_in  = 1'b0;
               k_in     = 2'd0;
               term_in  = 1'b0;
               degen_in = 1'b0;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            state_in = ST_XACC;
         end
         ST_XACC: begin
            // first term loads, second term subtracts
            vec_in[k_ff] = term_ff ? vec_ff[k_ff] - prod_ff : prod_ff;
            term_in      = ~term_ff;
            state_in     = ST_XMUL;
            if (term_ff) begin
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_CHECK;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_CHECK: begin
            if (vec_zero) begin
               for (int i = 0; i < 3; i++) begin
                  off_in[i] = '0;
                  if (!pass_ff) begin
                     nrm_in[i] = '0;
                  end
               end
               degen_in = ~pass_ff;
               state_in = ST_DONE;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vec_ff[i] < 0;
                  mag_in[i] = (vec_ff[i] < 0) ? ACC_W'(-vec_ff[i]) : ACC_W'(vec_ff[i]);
               end
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // shift all three together until each is below 2^30
            if (any_wide) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else begin
               k_in     = 2'd0;
               sum_in   = '0;
               state_in = ST_SQMUL;
            end
         end
         ST_SQMUL: begin
            state_in = ST_SQACC;
         end
         ST_SQACC: begin
            sum_in = sum_ff + prod_ff[RAD_W-1:0];
            if (k_ff == 2'd2) begin
               state_in = ST_ROOT_GO;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SQMUL;
            end
         end
         ST_ROOT_GO: begin
            sq_start = 1'b1;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sq_done) begin
               norm_in  = sq_root;
               k_in     = 2'd0;
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            dv_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (dv_done) begin
               if (pass_ff) begin
                  off_in[k_ff] = q_signed;
               end else begin
                  nrm_in[k_ff] = q_signed[NORM_W-1:0];
               end
               if (k_ff != 2'd2) begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_DMUL;
               end else if (!pass_ff) begin
                  // second pass: in-plane vector from the reduced normal
                  pass_in  = 1'b1;
                  k_in     = 2'd0;
                  term_in  = 1'b0;
                  state_in = ST_XMUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res.edge1[i] = sat24($signed({{2{mid_ff[i][COORD_W-1]}}, mid_ff[i]})
                              - (COORD_W+2)'(off_ff[i]));
         res.edge2[i] = sat24($signed({{2{mid_ff[i][COORD_W-1]}}, mid_ff[i]})
                              + (COORD_W+2)'(off_ff[i]));
         res.nrm[i]   = nrm_ff[i];
      end
      res.degen = degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pass_ff  <= pass_in;
      k_ff     <= k_in;
      term_ff  <= term_in;
      degen_ff <= degen_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      mid_ff   <= mid_in;
      vec_ff   <= vec_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      nrm_ff   <= nrm_in;
      off_ff   <= off_in;
      sum_ff   <= sum_in;
      norm_ff  <= norm_in;
      prod_ff  <= mul_a * mul_b;
   end

endmodule

/* rtl/peptide_ribbon_vertex.sv */
// Top level of the peptide ribbon vertex block: stream ports, atom phase,
// stored carbon and oxygen, output register. Depends on prv_pkg and prv_core.
//
//   Channel  Dir  Handshake              Payload
//   req_     in   req_tvalid/req_tready  tdata: atom x,y,z; tuser: start_req
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: edge1, edge2, normal; tuser: degenerate
//   csr_     in   csr_wr_en              csr_wr_data: half_width
//
// An oxygen or first carbon leaves the input open. A second carbon keeps the
// input blocked while the sequencer works, for a shorter time when the atoms
// are collinear: per pass a cross product on the shared multiplier, the common
// reduction shifts, a square root and three divides.
// Reset is synchronous and active high; half_width returns to 2.5 angstrom.
// A finished result waits in the output register; the input stays blocked
// until the sequencer has handed its result over and returned to idle.

module peptide_ribbon_vertex
   import prv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,    // atom_x [23:0], atom_y [47:24], atom_z [71:48]
   input  logic          req_tuser,    // start_req
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [191:0]  rsp_tdata,    // edge1_x/y/z [71:0], edge2_x/y/z [143:72],
                                       // normal_x/y/z [191:144]
   output logic          rsp_tuser,    // degenerate
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data   // half_width
);

   phase_type          phase_ff, phase_in, phase_eff;
   logic [HW_W-1:0]    hw_ff;
   logic [COORD_W-1:0] ca1_ff [3];
   logic [COORD_W-1:0] ca1_in [3];
   logic [COORD_W-1:0] oxy_ff [3];
   logic [COORD_W-1:0] oxy_in [3];
   logic [COORD_W-1:0] atom [3];
   logic               accept, job_go, core_idle;
   logic               res_valid, res_take;
   job_type            job;
   result_type         res, out_ff;
   logic               out_valid_ff, out_valid_in;

   assign atom[0]    = req_tdata[23:0];
   assign atom[1]    = req_tdata[47:24];
   assign atom[2]    = req_tdata[71:48];
   assign req_tready = core_idle;
   assign accept     = req_tvalid & req_tready;
   // a start request forces the first-carbon phase before the atom is taken
   assign phase_eff  = req_tuser ? PH_CA1 : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      ca1_in   = ca1_ff;
      oxy_in   = oxy_ff;
      job_go   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         job.a[i]   = DIFF_W'($signed(atom[i])) - DIFF_W'($signed(ca1_ff[i]));
         job.b[i]   = DIFF_W'($signed(oxy_ff[i])) - DIFF_W'($signed(ca1_ff[i]));
         job.mid[i] = COORD_W'((DIFF_W'($signed(atom[i])) + DIFF_W'($signed(ca1_ff[i])))
                               >>> 1);
      end
      if (accept) begin
         case (phase_eff)
            PH_OXY: begin
               oxy_in   = atom;
               phase_in = PH_CA2;
            end
            PH_CA2: begin
               // emit, then this carbon opens the next pair
               job_go   = 1'b1;
               ca1_in   = atom;
               phase_in = PH_OXY;
            end
            default: begin
               ca1_in   = atom;
               phase_in = PH_OXY;
            end
         endcase
      end
   end

   prv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .job_go     (job_go),
      .job        (job),
      .half_width (hw_ff),
      .idle       (core_idle),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res)
   );

   // output register: load when empty or when the current transfer completes
   assign res_take     = res_valid & (~out_valid_ff | rsp_tready);
   assign out_valid_in = res_take | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CA1;
         hw_ff        <= HW_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            hw_ff <= csr_wr_data;
         end
      end
      ca1_ff <= ca1_in;
      oxy_ff <= oxy_in;
      if (res_take) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.nrm, out_ff.edge2, out_ff.edge1};
   assign rsp_tuser  = out_ff.degen;

`ifndef NO_ASSERTIONS
   a_take_shows : assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_tvalid)
      else $error("result taken but not presented");
   a_emit_busy : assert property (@(posedge clock) disable iff (reset)
      job_go |=> !req_tready)
      else $error("sequencer ready right after launch");
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("waiting result changed");
`endif

endmodule

/* dv/peptide_ribbon_vertex_checker.sv */
// Scoreboard for the peptide ribbon vertex block: follows the atom stream,
// computes the expected ribbon vertex per second carbon, compares responses.
// Depends on prv_pkg for the phase encoding and the width reset value.
`timescale 1ns / 100ps

module peptide_ribbon_vertex_checker
   import prv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      logic [191:0] vertex;
      logic         degen;
   } vertex_type;

   vertex_type       vertex_q[$];
   phase_type        atom_phase;
   longint           carbon[3];
   longint           oxygen[3];
   logic [15:0]      width_reg;

   assign pending = vertex_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint magn(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint root_floor(input longint v);
      longint lo, hi, mid;
      lo = 0; hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // shrink by a common shift until every magnitude fits in 30 bits
   function automatic longint shrink(input longint v[3], output longint o[3]);
      longint mx, sum, r;
      int     sh;
      mx = 0; sum = 0; sh = 0;
      for (int i = 0; i < 3; i++) if (magn(v[i]) > mx) mx = magn(v[i]);
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
         r = magn(v[i]) >> sh;
         o[i] = v[i] < 0 ? -r : r;
         sum += r * r;
      end
      return root_floor(sum);
   endfunction

   function automatic longint scaled(input longint x, input longint k, input longint n);
      longint q;
      q = (magn(x) * k + n / 2) / n;
      return x < 0 ? -q : q;
   endfunction

   function automatic longint clip24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   task automatic predict_vertex(input longint p[3]);
      longint a[3], b[3], c[3], cs[3], d[3], ds[3], nrm[3], off[3];
      longint nc, nd, s, mid;
      vertex_type v;
      for (int i = 0; i < 3; i++) begin
         a[i] = p[i] - carbon[i];
         b[i] = oxygen[i] - carbon[i];
         nrm[i] = 0; off[i] = 0;
      end
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
      v.degen = (c[0] == 0 && c[1] == 0 && c[2] == 0);
      if (!v.degen) begin
         nc = shrink(c, cs);
         for (int i = 0; i < 3; i++) nrm[i] = scaled(cs[i], 16384, nc);
         d[0] = cs[1]*a[2] - cs[2]*a[1];
         d[1] = cs[2]*a[0] - cs[0]*a[2];
         d[2] = cs[0]*a[1] - cs[1]*a[0];
         if (d[0] != 0 || d[1] != 0 || d[2] != 0) begin
            nd = shrink(d, ds);
            for (int i = 0; i < 3; i++) off[i] = scaled(ds[i], width_reg, nd);
         end
      end
      for (int i = 0; i < 3; i++) begin
         s = carbon[i] + p[i];
         mid = s >>> 1;   // floor halving
         v.vertex[24*i +: 24]       = 24'(clip24(mid - off[i]));
         v.vertex[72 + 24*i +: 24]  = 24'(clip24(mid + off[i]));
         v.vertex[144 + 16*i +: 16] = 16'(nrm[i]);
      end
      vertex_q = {vertex_q, v};
   endtask

   always @(posedge clock) begin
      longint p[3];
      vertex_type w;
      if (reset) begin
         atom_phase <= PH_CA1;
         width_reg  <= HW_RESET;
         fail_count = 0;
      end else begin
         if (csr_wr_en) width_reg <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            for (int i = 0; i < 3; i++) p[i] = $signed(req_tdata[24*i +: 24]);
            if (!req_tuser && atom_phase == PH_OXY) begin
               oxygen = p;
               atom_phase <= PH_CA2;
            end else if (!req_tuser && atom_phase == PH_CA2) begin
               predict_vertex(p);
               carbon = p;
               atom_phase <= PH_OXY;
            end else begin
               carbon = p;
               atom_phase <= PH_OXY;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_q.size() == 0) begin
               report("vertex transfers beyond expected", 1, 0);
            end else begin
               w = vertex_q.pop_front();
               for (int i = 0; i < 6; i++)
                  if (rsp_tdata[24*i +: 24] !== w.vertex[24*i +: 24])
                     report($sformatf("edge word %0d", i),
                            $signed(rsp_tdata[24*i +: 24]),
                            $signed(w.vertex[24*i +: 24]));
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[144 + 16*i +: 16] !== w.vertex[144 + 16*i +: 16])
                     report($sformatf("normal %0d", i),
                            $signed(rsp_tdata[144 + 16*i +: 16]),
                            $signed(w.vertex[144 + 16*i +: 16]));
               if (rsp_tuser !== w.degen) report("degenerate", rsp_tuser, w.degen);
            end
         end
      end
   end

endmodule

/* dv/peptide_ribbon_vertex_tb.sv */
// Top of the peptide ribbon vertex testbench: clock, reset, atom stimulus,
// width register writes and the verdict. Depends on the block and
// peptide_ribbon_vertex_checker.
`timescale 1ns / 100ps

module peptide_ribbon_vertex_tb;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 0;
   logic [15:0]  csr_wr_data = '0;
   int           fail_count;
   int           pending;
   int           rsp_hold = 0;
   longint       cycle_count = 0;

   localparam longint CYCLE_LIMIT = 2_000_000;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   peptide_ribbon_vertex DUT (.*);

   peptide_ribbon_vertex_checker checker_i (.*);

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 60));
   endfunction

   function automatic logic [23:0] any_coord();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 80000) - 40000);
      endcase
   endfunction

   // hold the atom until it is taken, with a random gap before it
   task automatic send_atom(input logic start, input logic [23:0] x,
                            input logic [23:0] y, input logic [23:0] z);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= start;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_write(input logic [15:0] w);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);   // no vertex is pending, so the core is already idle
      csr_wr_en   <= 1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   task automatic random_atoms(input int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 49) == 0)
            send_atom(1'b1, any_coord(), any_coord(), any_coord());
         else if ($urandom_range(0, 29) == 0)   // an atom at the origin
            send_atom(1'b0, 24'd0, 24'd0, 24'd0);
         else
            send_atom(1'b0, any_coord(), any_coord(), any_coord());
      end
   endtask

   // stall the response side at random, now and then for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 0;
         rsp_hold   <= rsp_hold - 1;
      end else if ($urandom_range(0, 99) == 0) begin
         rsp_tready <= 0;
         rsp_hold   <= int'($urandom_range(10, 60));
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("peptide_ribbon_vertex verification failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: plain triple, collinear triple, extremes, start mid chain
      send_atom(1'b1, 24'd0, 24'd0, 24'd0);
      send_atom(1'b0, 24'd4096, 24'd4096, 24'd0);
      send_atom(1'b0, 24'd8192, 24'd0, 24'd0);
      send_atom(1'b0, 24'd12288, 24'd0, 24'd0);
      send_atom(1'b0, 24'd16384, 24'd0, 24'd0);
      send_atom(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_atom(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000);
      send_atom(1'b0, 24'h7FFFFF, 24'h800000, 24'h000001);
      send_atom(1'b1, 24'h800000, 24'h800000, 24'h800000);
      send_atom(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_atom(1'b1, 24'h000005, 24'hFFFFFB, 24'h000003);
      send_atom(1'b0, 24'hFFFFFF, 24'h000002, 24'h000007);
      send_atom(1'b0, 24'h000008, 24'hFFFFF0, 24'h000001);
      send_atom(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      drain_and_write(16'hFFFF);
      random_atoms(400);
      drain_and_write(16'h0000);
      random_atoms(400);
      drain_and_write(16'h0001);
      random_atoms(400);
      drain_and_write(16'($urandom));
      random_atoms(500);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("peptide_ribbon_vertex verification clean");
      else
         $display("peptide_ribbon_vertex verification failed");
      $finish;
   end

endmodule

/* peptide_ribbon_vertex.f */
rtl/prv_pkg.sv
rtl/prv_sqrt.sv
rtl/prv_div.sv
rtl/prv_core.sv
rtl/peptide_ribbon_vertex.sv
dv/peptide_ribbon_vertex_checker.sv
dv/peptide_ribbon_vertex_tb.sv
